@@ hdl/tq_pkg.sv @@
package tq_pkg;

    // sizes
    localparam int MAX_ELEMENTS = 1024;
    localparam int MAX_TEAMS    = 16;
    localparam int POOL_SLOTS   = 256;   // must not exceed MAX_ELEMENTS (shared init sweep)

    localparam int ELEM_W = $clog2(MAX_ELEMENTS);
    localparam int TEAM_W = $clog2(MAX_TEAMS);
    localparam int SLOT_W = $clog2(POOL_SLOTS);
    localparam int CNT_W  = $clog2(POOL_SLOTS + 1);
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;

    // stream beat widths, padded to whole bytes
    localparam int IN_W  = ((CMD_W + ELEM_W + TEAM_W + 7) / 8) * 8;
    localparam int OUT_W = ((ELEM_W + STAT_W + 7) / 8) * 8;

    // commands
    localparam logic [CMD_W-1:0] CMD_SET = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENQ = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEQ = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

endpackage

@@ hdl/tq_ram.sv @@
module tq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/team_queue.sv @@
// Team queue (grouped FIFO). Each beat on the slave side carries one command:
// set the team of an element, enqueue an element, or dequeue the front
// element; each command answers with exactly one beat on the master side
// (element_out, status). An enqueued element lines up behind the last waiting
// member of its team, or opens a new team group at the tail of the team order.
// A dequeue takes the front element of the front team. Commands never
// overlap: the accept cycle issues reads of the team map and the slot pool
// memories, the next cycle consumes the registered read data and writes back.
// After reset the block sweeps all MAX_ELEMENTS (1024) entries, clearing the
// team map to team 0 and threading the free-slot list; tready stays low
// during that sweep. A new command is taken while the previous answer is
// still on the master side, provided that answer is taken in the same cycle.
module team_queue
    import tq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,   // command[1:0], element[11:2], team[15:12]
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata    // element_out[9:0], status[11:10], zero pad
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    localparam logic [ELEM_W-1:0] CLR_LAST = ELEM_W'(MAX_ELEMENTS - 1);

    // control
    logic [1:0]        r_state, n_state;
    logic [ELEM_W-1:0] r_clr_cnt;

    // command being executed
    logic [CMD_W-1:0]  r_cmd;
    logic [ELEM_W-1:0] r_elem;
    logic [TEAM_W-1:0] r_team;
    logic [TEAM_W-1:0] r_deq_team;
    logic [SLOT_W-1:0] r_deq_slot;

    // per-team tables
    logic [SLOT_W-1:0] r_team_first [MAX_TEAMS];
    logic [SLOT_W-1:0] r_team_last  [MAX_TEAMS];
    logic [TEAM_W-1:0] r_team_order [MAX_TEAMS];
    logic [CNT_W-1:0]  r_team_wait  [MAX_TEAMS];
    logic [TEAM_W-1:0] r_order_head;
    logic [TEAM_W-1:0] r_order_tail;

    // pool bookkeeping: free slots form a list through the link memory
    logic [SLOT_W-1:0] r_free_head;
    logic [CNT_W-1:0]  r_free_count;
    logic [CNT_W-1:0]  r_total;

    // answer register
    logic              r_out_valid;
    logic [ELEM_W-1:0] r_out_elem;
    logic [STAT_W-1:0] r_out_status;

    // input beat fields
    logic [CMD_W-1:0]  in_cmd;
    logic [ELEM_W-1:0] in_elem;
    logic [TEAM_W-1:0] in_team;
    logic              s_acc;

    assign in_cmd  = i_s_tdata[CMD_W-1:0];
    assign in_elem = i_s_tdata[CMD_W+ELEM_W-1:CMD_W];
    assign in_team = i_s_tdata[CMD_W+ELEM_W+TEAM_W-1:CMD_W+ELEM_W];

    // take a beat only if the answer slot is free by the next edge
    assign o_s_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_tready);
    assign s_acc      = i_s_tvalid && o_s_tready;

    // front of the queue as seen at accept time
    logic [TEAM_W-1:0] front_team;
    logic [SLOT_W-1:0] front_slot;
    assign front_team = r_team_order[r_order_head];
    assign front_slot = r_team_first[front_team];

    // memory ports
    logic              map_we;
    logic [ELEM_W-1:0] map_waddr;
    logic [TEAM_W-1:0] map_wdata;
    logic [TEAM_W-1:0] map_rdata;
    logic              link_we;
    logic [SLOT_W-1:0] link_waddr, link_wdata, link_raddr, link_rdata;
    logic              val_we;
    logic [ELEM_W-1:0] val_rdata;

    // execute-cycle decode
    logic              in_exec;
    logic              enq_ok, deq_ok;
    logic [TEAM_W-1:0] ex_team;
    logic              team_busy;
    logic [CNT_W-1:0]  wait_dec;

    assign in_exec   = (r_state == ST_EXEC);
    assign enq_ok    = in_exec && (r_cmd == CMD_ENQ) && (r_free_count != '0);
    assign deq_ok    = in_exec && (r_cmd == CMD_DEQ) && (r_total != '0);
    assign ex_team   = (r_cmd == CMD_DEQ) ? r_deq_team : map_rdata;
    assign team_busy = (r_team_wait[ex_team] != '0);
    assign wait_dec  = r_team_wait[ex_team] - CNT_W'(1);

    // team map: cleared by the sweep, written by set-team, read at accept
    always_comb begin
        if (r_state == ST_CLEAR) begin
            map_we    = 1'b1;
            map_waddr = r_clr_cnt;
            map_wdata = '0;
        end else begin
            map_we    = in_exec && (r_cmd == CMD_SET);
            map_waddr = r_elem;
            map_wdata = r_team;
        end
    end

    // link memory: sweep threads slot i to i+1; enqueue appends to a team's
    // chain; dequeue pushes the freed slot onto the free list
    always_comb begin
        link_we    = 1'b0;
        link_waddr = r_deq_slot;
        link_wdata = r_free_head;
        if (r_state == ST_CLEAR) begin
            link_we    = (r_clr_cnt < ELEM_W'(POOL_SLOTS));
            link_waddr = r_clr_cnt[SLOT_W-1:0];
            link_wdata = r_clr_cnt[SLOT_W-1:0] + SLOT_W'(1);
        end else if (enq_ok && team_busy) begin
            link_we    = 1'b1;
            link_waddr = r_team_last[ex_team];
            link_wdata = r_free_head;
        end else if (deq_ok) begin
            link_we    = 1'b1;
            link_waddr = r_deq_slot;
            link_wdata = r_free_head;
        end
    end

    // dequeue reads the successor of the front slot, enqueue the next free slot
    assign link_raddr = (in_cmd == CMD_DEQ) ? front_slot : r_free_head;
    assign val_we     = enq_ok;

    tq_ram #(.WIDTH(TEAM_W), .DEPTH(MAX_ELEMENTS)) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (in_elem),
        .o_rdata (map_rdata)
    );

    tq_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_SLOTS)) u_link (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    tq_ram #(.WIDTH(ELEM_W), .DEPTH(POOL_SLOTS)) u_value (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (r_free_head),
        .i_wdata (r_elem),
        .i_raddr (front_slot),
        .o_rdata (val_rdata)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_cnt == CLR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + ELEM_W'(1);
            end
        end
    end

    // command capture
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_cmd      <= in_cmd;
            r_elem     <= in_elem;
            r_team     <= in_team;
            r_deq_team <= front_team;
            r_deq_slot <= front_slot;
        end
    end

    // per-team pointers and team order (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (enq_ok) begin
            if (!team_busy) begin
                r_team_first[ex_team]      <= r_free_head;
                r_team_order[r_order_tail] <= ex_team;
            end
            r_team_last[ex_team] <= r_free_head;
        end else if (deq_ok) begin
            r_team_first[ex_team] <= link_rdata;
        end
    end

    // counts, ring pointers, free list head
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TEAMS; i++) begin
                r_team_wait[i] <= '0;
            end
            r_order_head <= '0;
            r_order_tail <= '0;
            r_free_head  <= '0;
            r_free_count <= CNT_W'(POOL_SLOTS);
            r_total      <= '0;
        end else if (enq_ok) begin
            r_team_wait[ex_team] <= r_team_wait[ex_team] + CNT_W'(1);
            if (!team_busy) begin
                r_order_tail <= r_order_tail + TEAM_W'(1);
            end
            r_free_head  <= link_rdata;
            r_free_count <= r_free_count - CNT_W'(1);
            r_total      <= r_total + CNT_W'(1);
        end else if (deq_ok) begin
            r_team_wait[ex_team] <= wait_dec;
            if (wait_dec == '0) begin
                r_order_head <= r_order_head + TEAM_W'(1);
            end
            r_free_head  <= r_deq_slot;
            r_free_count <= r_free_count + CNT_W'(1);
            r_total      <= r_total - CNT_W'(1);
        end
    end

    // answer register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_exec) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_exec) begin
            r_out_elem   <= deq_ok ? val_rdata : '0;
            if ((r_cmd == CMD_DEQ) && !deq_ok) begin
                r_out_status <= STAT_EMPTY;
            end else if ((r_cmd == CMD_ENQ) && !enq_ok) begin
                r_out_status <= STAT_FULL;
            end else begin
                r_out_status <= STAT_OK;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_W - ELEM_W - STAT_W){1'b0}}, r_out_status, r_out_elem};

    // pool slots are either free or holding a waiting element
    a_pool_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_free_count} + {1'b0, r_total}) == (CNT_W + 1)'(POOL_SLOTS))
        else $error("pool slot accounting broken");

    // an accepted command is executed in the very next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_state == ST_EXEC))
        else $error("accepted command not executed");

    // every executed command produces an answer beat
    a_exec_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_exec |=> o_m_tvalid)
        else $error("executed command left no answer");

    // a dequeue with elements waiting never reports empty
    a_deq_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_exec && (r_cmd == CMD_DEQ) && (r_total != '0)) |=> (r_out_status == STAT_OK))
        else $error("dequeue reported empty with elements waiting");

    // the front team of a nonempty queue has members
    a_front_team: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_IDLE) && (r_total != '0)) |-> (r_team_wait[front_team] != '0))
        else $error("front team has no waiting members");

endmodule
